// File: rtl/radial_lens_shading_apply_defines.svh
// Assertion macros for the radial lens shading block.
// Used by files that check behaviour; they expect signals clk and rst in scope.
`ifndef RADIAL_LENS_SHADING_APPLY_DEFINES_SVH
`define RADIAL_LENS_SHADING_APPLY_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LSA_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lsa assertion failed");

// Next-cycle implication, disabled during reset.
`define LSA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lsa assertion failed");

`endif

// File: rtl/lsa_pkg.sv
// Package for the radial lens shading block: constants, types and helpers.
// No dependencies; all block files but the RAM and macro header import it.
`default_nettype none
package lsa_pkg;

  // Table geometry.
  localparam int NODE_COUNT  = 129;
  localparam int SEG         = NODE_COUNT - 1;
  localparam int SEG_W       = $clog2(SEG);
  localparam int BIT_W       = $clog2(SEG_W);
  localparam int TAB_DEPTH   = 4 * NODE_COUNT;
  localparam int TAB_AW      = $clog2(TAB_DEPTH);
  localparam int MAX_DIM     = 8192;

  // Field and datapath widths.
  localparam int DIM_W   = 14;
  localparam int HALF_W  = 13;
  localparam int POS_W   = 13;
  localparam int PIX_W   = 16;
  localparam int GAIN_W  = 16;
  localparam int NODE_W  = 8;
  localparam int R_W     = 2 * POS_W + 1;
  localparam int RMAX_W  = 2 * HALF_W;
  localparam int STEP_W  = RMAX_W - SEG_W;
  localparam int DEN_W   = STEP_W;
  localparam int DVD_W   = GAIN_W + DEN_W;
  localparam int PROD_W  = PIX_W + GAIN_W;
  localparam int CIDX_W  = 3;
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam logic [GAIN_W-1:0] CENTER_GAIN = GAIN_W'(4096);

  // Item operation codes.
  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_WRITE = 1'b1
  } op_t;

  // Configuration register indexes.
  typedef enum logic [CIDX_W-1:0] {
    CFG_WIDTH  = 3'd0,
    CFG_HEIGHT = 3'd1,
    CFG_DEPTH  = 3'd2,
    CFG_SCALE  = 3'd3,
    CFG_FORMAT = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
    logic [4:0]       depth;
    logic [2:0]       scale;
    logic [1:0]       format;
  } cfg_t;

  // Classified word passed from the front to the back.
  typedef struct packed {
    op_t               op;
    logic              wr_ok;
    logic [TAB_AW-1:0] waddr;
    logic [GAIN_W-1:0] gain;
    logic [1:0]        chan;
    logic [POS_W-1:0]  adx;
    logic [POS_W-1:0]  ady;
    logic [PIX_W-1:0]  pix;
  } q_entry_t;

  typedef enum logic [3:0] {
    B_IDLE, B_RSQ, B_MSQ, B_SRCH, B_RD0, B_RD1, B_RD2,
    B_DINI, B_DIV, B_DFIN, B_MUL, B_SAT, B_OUT
  } bst_t;

  // Half of a dimension, clamped to the largest supported size.
  function automatic logic [HALF_W-1:0] half_dim(input logic [DIM_W-1:0] d);
    logic [DIM_W-1:0] c;
    c = (d > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : d;
    return c[DIM_W-1:1];
  endfunction

  // Bayer colour channel: the format code flipped by row and column parity.
  function automatic logic [1:0] bayer_chan(input logic [1:0] fmt,
                                            input logic row0, input logic col0);
    return fmt ^ {row0, col0};
  endfunction

endpackage
`default_nettype wire

// File: rtl/lsa_in_if.sv
// Input channel: one pixel or table write word with valid/ready.
// Depends on lsa_pkg for field widths.
`default_nettype none
interface lsa_in_if;
  import lsa_pkg::*;
  logic              valid;
  logic              ready;
  logic              op;
  logic [POS_W-1:0]  col;
  logic [POS_W-1:0]  row;
  logic [PIX_W-1:0]  pixel_in;
  logic [1:0]        channel;
  logic [NODE_W-1:0] node;
  logic [GAIN_W-1:0] gain;
  modport source (output valid, op, col, row, pixel_in, channel, node, gain,
                  input ready);
  modport sink   (input valid, op, col, row, pixel_in, channel, node, gain,
                  output ready);
endinterface
`default_nettype wire

// File: rtl/lsa_out_if.sv
// Output channel: one corrected pixel word with valid/ready.
// Depends on lsa_pkg for the field width.
`default_nettype none
interface lsa_out_if;
  import lsa_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_out;
  modport source (output valid, pixel_out, input ready);
  modport sink   (input valid, pixel_out, output ready);
endinterface
`default_nettype wire

// File: rtl/lsa_cfg_if.sv
// Configuration write channel: register index and data with valid/ready.
// Depends on lsa_pkg for widths.
`default_nettype none
interface lsa_cfg_if;
  import lsa_pkg::*;
  logic              valid;
  logic              ready;
  logic [CIDX_W-1:0] index;
  logic [DIM_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: rtl/lsa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none
module lsa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: rtl/lsa_front.sv
// Front end: accepts words, classifies them and prepares table and geometry fields.
// Depends on lsa_pkg and lsa_in_if.
`default_nettype none
module lsa_front (
  lsa_in_if.sink               item,
  input  wire lsa_pkg::cfg_t     cfg,
  input  wire logic              full,
  output logic                   push,
  output lsa_pkg::q_entry_t      entry
);
  import lsa_pkg::*;

  logic [HALF_W-1:0] cx;
  logic [HALF_W-1:0] cy;

  // Accept whenever the queue has room.
  assign item.ready = !full;
  assign push       = item.valid && !full;

  assign cx = half_dim(cfg.width);
  assign cy = half_dim(cfg.height);

  // Absolute offsets to the centre, colour channel and write address.
  always_comb begin
    entry.op    = op_t'(item.op);
    entry.wr_ok = ({1'b0, item.node} < (NODE_W + 1)'(NODE_COUNT));
    entry.waddr = TAB_AW'(item.channel * NODE_COUNT + item.node);
    entry.gain  = item.gain;
    entry.chan  = bayer_chan(cfg.format, item.row[0], item.col[0]);
    entry.adx   = (item.col >= cx) ? POS_W'(item.col - cx) : POS_W'(cx - item.col);
    entry.ady   = (item.row >= cy) ? POS_W'(item.row - cy) : POS_W'(cy - item.row);
    entry.pix   = item.pixel_in;
  end
endmodule
`default_nettype wire

// File: rtl/lsa_fifo.sv
// Short queue between front and back so that each side can stall on its own.
// Depends on lsa_pkg.
`default_nettype none
module lsa_fifo (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire lsa_pkg::q_entry_t wdata,
  input  wire logic              pop,
  output logic                   valid,
  output logic                   full,
  output lsa_pkg::q_entry_t      rdata
);
  import lsa_pkg::*;

  q_entry_t            slots [QDEPTH];
  logic [QPTR_W-1:0]   wptr;
  logic [QPTR_W-1:0]   rptr;
  logic [QCNT_W-1:0]   count;

  assign valid = (count != '0);
  assign full  = (count == QCNT_W'(QDEPTH));
  assign rdata = slots[rptr];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == QPTR_W'(QDEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == QPTR_W'(QDEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= wdata;
    end
  end
endmodule
`default_nettype wire

// File: rtl/lsa_back.sv
// Back end: radius, node search, table reads, interpolation divide, gain and clip.
// Depends on lsa_pkg, lsa_out_if and lsa_ram.
`default_nettype none
module lsa_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire lsa_pkg::cfg_t     cfg,
  input  wire logic              q_valid,
  input  wire lsa_pkg::q_entry_t q_data,
  output logic                   q_pop,
  lsa_out_if.source              result
);
  import lsa_pkg::*;

  bst_t                state;
  bst_t                state_next;

  logic [POS_W-1:0]    adx;
  logic [POS_W-1:0]    ady;
  logic [1:0]          chan;
  logic [PIX_W-1:0]    pix;
  logic [R_W-1:0]      r;
  logic [RMAX_W-1:0]   rmax;
  logic [STEP_W-1:0]   step;
  logic [SEG_W-1:0]    m;
  logic [BIT_W-1:0]    bitn;
  logic                hit1;
  logic [DEN_W-1:0]    numv;
  logic [DEN_W-1:0]    den;
  logic [GAIN_W-1:0]   g0;
  logic [DVD_W-1:0]    dvd;
  logic                neg;
  logic [DEN_W-1:0]    rem;
  logic [GAIN_W-1:0]   quo;
  logic [3:0]          cnt;
  logic [GAIN_W-1:0]   g;
  logic [PROD_W-1:0]   mprod;
  logic [PIX_W-1:0]    pout;

  logic [HALF_W-1:0]   cx;
  logic [HALF_W-1:0]   cy;
  logic [SEG_W-1:0]    trial;
  logic [RMAX_W-1:0]   tprod;
  logic [RMAX_W-1:0]   x0;
  logic [RMAX_W-1:0]   x1;
  logic [DEN_W:0]      dtmp;
  logic                dge;
  logic                gneg;
  logic [GAIN_W-1:0]   gdiff;
  logic [PROD_W-1:0]   shifted;
  logic [PIX_W:0]      maxv;

  logic                ram_we;
  logic [TAB_AW-1:0]   raddr;
  logic [GAIN_W-1:0]   rdata;

  lsa_ram #(.WIDTH(GAIN_W), .DEPTH(TAB_DEPTH)) u_tab (
    .clk   (clk),
    .we    (ram_we),
    .waddr (q_data.waddr),
    .wdata (q_data.gain),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign cx = half_dim(cfg.width);
  assign cy = half_dim(cfg.height);

  // Node search trial: set the next bit of the count of thresholds below R.
  assign trial = m | (SEG_W'(1) << bitn);
  assign tprod = RMAX_W'(trial * step);

  // Bounding thresholds for node m+1; the last node ends at the full radius.
  assign x0 = RMAX_W'(m * step);
  assign x1 = (m == SEG_W'(SEG - 1)) ? rmax : x0 + RMAX_W'(step);

  // One restoring divide step.
  assign dtmp = {rem, quo[GAIN_W-1]};
  assign dge  = (dtmp >= {1'b0, den});

  // Signed gain difference between the two bounding nodes.
  assign gneg  = (rdata < g0);
  assign gdiff = gneg ? g0 - rdata : rdata - g0;

  // Fixed-point realignment and clip level.
  assign shifted = mprod >> (4'd15 - {1'b0, cfg.scale});
  assign maxv    = (cfg.depth >= 5'd16) ? (PIX_W + 1)'(17'h0FFFF)
                 : ((PIX_W + 1)'(1) << cfg.depth) - 1'b1;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, queue pop, table port and result handshake.
  always_comb begin
    state_next   = state;
    q_pop        = 1'b0;
    ram_we       = 1'b0;
    raddr        = TAB_AW'(chan * NODE_COUNT + m);
    result.valid = 1'b0;
    unique case (state)
      B_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_data.op == OP_WRITE) begin
            ram_we = q_data.wr_ok;
          end else begin
            state_next = B_RSQ;
          end
        end
      end
      B_RSQ:  state_next = B_MSQ;
      B_MSQ:  state_next = (r == '0) ? B_MUL : B_SRCH;
      B_SRCH: state_next = (bitn == '0) ? B_RD0 : B_SRCH;
      B_RD0:  state_next = B_RD1;
      B_RD1: begin
        raddr      = TAB_AW'(chan * NODE_COUNT + m + 1);
        state_next = B_RD2;
      end
      B_RD2:  state_next = hit1 ? B_MUL : B_DINI;
      B_DINI: state_next = B_DIV;
      B_DIV:  state_next = (cnt == '0) ? B_DFIN : B_DIV;
      B_DFIN: state_next = B_MUL;
      B_MUL:  state_next = B_SAT;
      B_SAT:  state_next = B_OUT;
      B_OUT: begin
        result.valid = 1'b1;
        if (result.ready) begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  assign result.pixel_out = pout;

  // Datapath registers, loaded per state.
  always_ff @(posedge clk) begin
    unique case (state)
      B_IDLE: begin
        adx  <= q_data.adx;
        ady  <= q_data.ady;
        chan <= q_data.chan;
        pix  <= q_data.pix;
      end
      B_RSQ: begin
        r <= R_W'(adx * adx) + R_W'(ady * ady);
      end
      B_MSQ: begin
        rmax <= RMAX_W'(cx * cx) + RMAX_W'(cy * cy);
        m    <= '0;
        bitn <= BIT_W'(SEG_W - 1);
        g    <= CENTER_GAIN;
      end
      B_SRCH: begin
        // The segment count is a power of two, so the step is a shift.
        if (bitn == BIT_W'(SEG_W - 1)) begin
          step <= STEP_W'(rmax >> SEG_W);
        end
        if (bitn != BIT_W'(SEG_W - 1) && {1'b0, r} > {2'b00, tprod}) begin
          m <= trial;
        end
        if (bitn == BIT_W'(SEG_W - 1) && r > R_W'(RMAX_W'(trial * (rmax >> SEG_W)))) begin
          m <= trial;
        end
        bitn <= bitn - 1'b1;
      end
      B_RD0: begin
        hit1 <= ({1'b0, r} >= {2'b00, x1});
        numv <= DEN_W'(r - R_W'(x0));
        den  <= DEN_W'(x1 - x0);
      end
      B_RD1: begin
        g0 <= rdata;
      end
      B_RD2: begin
        g   <= rdata;
        neg <= gneg;
        dvd <= DVD_W'(gdiff * numv);
      end
      B_DINI: begin
        rem <= dvd[DVD_W-1:GAIN_W];
        quo <= dvd[GAIN_W-1:0];
        cnt <= 4'd15;
      end
      B_DIV: begin
        rem <= dge ? DEN_W'(dtmp - {1'b0, den}) : dtmp[DEN_W-1:0];
        quo <= {quo[GAIN_W-2:0], dge};
        cnt <= cnt - 1'b1;
      end
      B_DFIN: begin
        g <= neg ? g0 - quo : g0 + quo;
      end
      B_MUL: begin
        mprod <= PROD_W'(pix * g);
      end
      B_SAT: begin
        pout <= (shifted > PROD_W'(maxv)) ? maxv[PIX_W-1:0] : shifted[PIX_W-1:0];
      end
      B_OUT: begin
        pout <= pout;
      end
      default: begin
        pout <= pout;
      end
    endcase
  end
endmodule
`default_nettype wire

// File: rtl/radial_lens_shading_apply.sv
// A pixel passes radius, node search, table reads, divide, gain and clip states;
// search, reads and divide are skipped at the exact image centre, and the divide
// when the radius reaches the far bounding node. The back works on one pixel at a
// time, paced by the 7-step node search and the 16-step interpolation divider.
// With the back idle, table writes retire one per cycle via the two-word queue.
// Synchronous active-high reset clears control state and loads the register
// defaults; gain table contents are undefined until written.
`default_nettype none
`include "radial_lens_shading_apply_defines.svh"
module radial_lens_shading_apply (
  input wire logic clk,
  input wire logic rst,
  lsa_in_if.sink    item,
  lsa_out_if.source result,
  lsa_cfg_if.sink   cfg
);
  import lsa_pkg::*;

  cfg_t     regs;
  logic     push;
  logic     q_full;
  logic     q_valid;
  logic     q_pop;
  q_entry_t push_entry;
  q_entry_t q_entry;

  // Configuration registers; writes are always taken.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.width  <= DIM_W'(1920);
      regs.height <= DIM_W'(1080);
      regs.depth  <= 5'd12;
      regs.scale  <= 3'd3;
      regs.format <= 2'd0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_WIDTH:  regs.width  <= cfg.data;
        CFG_HEIGHT: regs.height <= cfg.data;
        CFG_DEPTH:  regs.depth  <= cfg.data[4:0];
        CFG_SCALE:  regs.scale  <= cfg.data[2:0];
        CFG_FORMAT: regs.format <= cfg.data[1:0];
        default:    regs        <= regs;
      endcase
    end
  end

  lsa_front u_front (
    .item  (item),
    .cfg   (regs),
    .full  (q_full),
    .push  (push),
    .entry (push_entry)
  );

  lsa_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (push_entry),
    .pop   (q_pop),
    .valid (q_valid),
    .full  (q_full),
    .rdata (q_entry)
  );

  lsa_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (regs),
    .q_valid (q_valid),
    .q_data  (q_entry),
    .q_pop   (q_pop),
    .result  (result)
  );

  // The back only takes a word the queue actually holds.
  `LSA_ASSERT_IMPL(a_pop_has_data, q_pop, q_valid)
  // A delivered result is never shown again in the next cycle.
  `LSA_ASSERT_NEXT(a_no_repeat, result.valid && result.ready, !result.valid)
  // A word pushed with no pop leaves the queue non-empty.
  `LSA_ASSERT_NEXT(a_push_lands, push && !q_pop, q_valid)
endmodule
`default_nettype wire
